/* hw/rtl/bfat_pkg.sv */
// Shared types and constants for the Bloom filter add/test core.
`default_nettype none

package bfat_pkg;

  // Default sizing of the filter store and the probe sequencer.
  localparam int unsigned MAX_BITS_DEF   = 65536;
  localparam int unsigned MAX_PROBES_DEF = 16;

  // Keys are hashed as fixed eight-byte little-endian words.
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned BYTE_CNT_W  = $clog2(KEY_BYTES);
  localparam int unsigned STORE_W     = 8;

  // Configuration register widths, limits and reset values.
  localparam int unsigned             BIT_COUNT_W    = 17;
  localparam int unsigned             HASH_COUNT_W   = 5;
  localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST  = 17'd65536;
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 5'd7;
  localparam int unsigned             MIN_BITS       = 64;

  // APB-style register port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // FNV-1a: the 64-bit prime is 2^40 + 0x1b3.
  localparam logic [KEY_W-1:0] FNV_BASIS       = 64'hcbf29ce484222325;
  localparam int unsigned      FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]       FNV_PRIME_LO    = 9'h1b3;

  // Second hash: h2 = h1 * GOLD_MUL + GOLD_ADD.
  localparam logic [KEY_W-1:0] GOLD_MUL = 64'h9e3779b97f4a7c15;
  localparam logic [KEY_W-1:0] GOLD_ADD = 64'h517cc1b727220a95;

  // Partial product sequencing of the 64x64 multiply and the remainder unit.
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned MUL_STEPS = 4;
  localparam int unsigned MUL_CW    = $clog2(MUL_STEPS);
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = KEY_W / DIV_BITS;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic {
    REG_BIT_COUNT  = 1'b0,
    REG_HASH_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MUL,
    ST_DIV,
    ST_PREP,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/bloom_filter_add_test_core.sv */
// Bloom filter core: FNV-1a hashing, double-hash probe sequencer and bit store.
// From its transfer an item goes through one hash step per key byte, the multiply, the
// remainder steps, a setup step, one store read and one store update per probe (n, the
// probe count, is 0 to 16) and a finish step; the next item is taken back in idle.
// A test result is loaded in the finish step, which waits while the result register is full; a failed probe ends early.
// After reset the store is cleared one byte per cycle (MAX_BITS/8 bytes, 8192 by default).
`default_nettype none

module bloom_filter_add_test_core #(
  parameter int unsigned MAX_BITS   = bfat_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_PROBES = bfat_pkg::MAX_PROBES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Item input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [bfat_pkg::KEY_W-1:0]    key_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               present_o,
  // Register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bfat_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bfat_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bfat_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int unsigned DEPTH = (MAX_BITS + bfat_pkg::STORE_W - 1) / bfat_pkg::STORE_W;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(MAX_BITS);
  localparam int unsigned MW    = $clog2(MAX_BITS + 1);
  localparam int unsigned KW    = $clog2(MAX_PROBES + 1);

  localparam int unsigned KEY_W  = bfat_pkg::KEY_W;
  localparam int unsigned HALF_W = bfat_pkg::HALF_W;
  localparam int unsigned SW     = bfat_pkg::STORE_W;

  // One remainder step: shift in one dividend bit and subtract the modulus if the result is not below it.
  function automatic logic [RW-1:0] rem_step(input logic [RW-1:0] rem,
                                             input logic din,
                                             input logic [RW:0] modv);
    logic [RW:0] trial;
    trial = {rem, din};
    if (trial >= modv) begin
      rem_step = RW'(trial - modv);
    end else begin
      rem_step = RW'(trial);
    end
  endfunction

  // Control state
  bfat_pkg::state_e                     state_q, state_d;
  logic [AW-1:0]                        clr_cnt_q;
  logic [bfat_pkg::BYTE_CNT_W-1:0]      byte_cnt_q;
  logic [bfat_pkg::MUL_CW-1:0]          mul_cnt_q;
  logic [bfat_pkg::DIV_CW-1:0]          div_cnt_q;
  logic [KW-1:0]                        probe_cnt_q;
  logic                                 out_valid_q;
  logic [bfat_pkg::BIT_COUNT_W-1:0]     bit_count_q;
  logic [bfat_pkg::HASH_COUNT_W-1:0]    hash_count_q;

  // Datapath
  logic [KEY_W-1:0]  key_q;
  bfat_pkg::op_e     op_q;
  logic [MW-1:0]     m_q;
  logic [KW-1:0]     n_q;
  logic [KEY_W-1:0]  h_q;
  logic [KEY_W-1:0]  h2_q;
  logic [KEY_W-1:0]  prod_q;
  logic [RW-1:0]     pos_q;
  logic [RW-1:0]     h2m_q;
  logic [RW-1:0]     t_q;
  logic [RW-1:0]     d2_q;
  logic              all_set_q;
  logic              present_q;

  // Combinational signals
  logic [MW-1:0]     m_cfg;
  logic [KW-1:0]     n_cfg;
  logic [RW:0]       m_ext;
  logic [7:0]        key_byte;
  logic [KEY_W-1:0]  fnv_x;
  logic [72:0]       fnv_lo;
  logic [KEY_W-1:0]  fnv_next;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [KEY_W-1:0]  mul_p;
  logic [bfat_pkg::DIV_CW-1:0] nib_idx;
  logic [bfat_pkg::DIV_BITS-1:0] nib_h1, nib_h2;
  logic [RW-1:0]     r1_n, r2_n, rt_n;
  logic [RW:0]       d2_calc;
  logic [KEY_W:0]    x_sum;
  logic [RW-1:0]     inc;
  logic [RW:0]       r_sum;
  logic [RW-1:0]     r_nx;
  logic              probe_last;
  logic              bit_hit;
  logic [SW-1:0]     bit_mask;
  logic              out_free;
  logic              in_xfer;
  logic              cfg_write;

  // Memory and handshake controls
  logic              mem_we, mem_re, out_load;
  logic [AW-1:0]     mem_waddr, byte_addr;
  logic [SW-1:0]     mem_wdata, mem_rdata;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (bfat_pkg::reg_idx_e'(paddr[bfat_pkg::PADDR_W-1]))
      bfat_pkg::REG_BIT_COUNT:  prdata = bfat_pkg::PDATA_W'(bit_count_q);
      bfat_pkg::REG_HASH_COUNT: prdata = bfat_pkg::PDATA_W'(hash_count_q);
      default:                  prdata = '0;
    endcase
  end

  // Out-of-range register values behave as the nearest limit.
  always_comb begin
    if (32'(bit_count_q) < 32'(bfat_pkg::MIN_BITS)) begin
      m_cfg = MW'(bfat_pkg::MIN_BITS);
    end else if (32'(bit_count_q) > 32'(MAX_BITS)) begin
      m_cfg = MW'(MAX_BITS);
    end else begin
      m_cfg = MW'(bit_count_q);
    end
    if (32'(hash_count_q) > 32'(MAX_PROBES)) begin
      n_cfg = KW'(MAX_PROBES);
    end else begin
      n_cfg = KW'(hash_count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  assign m_ext   = (RW + 1)'(m_q);
  assign in_xfer = in_valid_i && in_ready_o;

  // FNV-1a byte step; the prime multiply is a shift plus a narrow product.
  assign key_byte = key_q[byte_cnt_q * 8 +: 8];
  assign fnv_x    = h_q ^ KEY_W'(key_byte);
  assign fnv_lo   = fnv_x * bfat_pkg::FNV_PRIME_LO;
  assign fnv_next = (fnv_x << bfat_pkg::FNV_PRIME_SHIFT) + fnv_lo[KEY_W-1:0];

  // Low 64 bits of h1 * GOLD_MUL from three 32x32 partial products.
  always_comb begin
    case (mul_cnt_q)
      2'd0: begin
        mul_a = h_q[HALF_W-1:0];
        mul_b = bfat_pkg::GOLD_MUL[HALF_W-1:0];
      end
      2'd1: begin
        mul_a = h_q[HALF_W-1:0];
        mul_b = bfat_pkg::GOLD_MUL[KEY_W-1:HALF_W];
      end
      2'd2: begin
        mul_a = h_q[KEY_W-1:HALF_W];
        mul_b = bfat_pkg::GOLD_MUL[HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Three remainder lanes share the step count: h1 mod m, h2 mod m and 2^64 mod m.
  assign nib_idx = bfat_pkg::DIV_CW'(bfat_pkg::DIV_STEPS - 1) - div_cnt_q;
  assign nib_h1  = h_q[nib_idx * bfat_pkg::DIV_BITS +: bfat_pkg::DIV_BITS];
  assign nib_h2  = h2_q[nib_idx * bfat_pkg::DIV_BITS +: bfat_pkg::DIV_BITS];

  always_comb begin
    r1_n = pos_q;
    r2_n = h2m_q;
    rt_n = t_q;
    for (int j = bfat_pkg::DIV_BITS - 1; j >= 0; j--) begin
      r1_n = rem_step(r1_n, nib_h1[j], m_ext);
      r2_n = rem_step(r2_n, nib_h2[j], m_ext);
      rt_n = rem_step(rt_n, 1'b0, m_ext);
    end
  end

  // Increment used when the 64-bit probe sum wraps: (h2 - 2^64) mod m.
  always_comb begin
    if (h2m_q >= t_q) begin
      d2_calc = {1'b0, h2m_q} - {1'b0, t_q};
    end else begin
      d2_calc = {1'b0, h2m_q} + m_ext - {1'b0, t_q};
    end
  end

  // The probe position advances in the residue domain, tracking the wrap of h1 + k*h2.
  assign x_sum = {1'b0, h_q} + {1'b0, h2_q};
  assign inc   = x_sum[KEY_W] ? d2_q : h2m_q;
  assign r_sum = {1'b0, pos_q} + {1'b0, inc};
  assign r_nx  = (r_sum >= m_ext) ? RW'(r_sum - m_ext) : RW'(r_sum);

  assign byte_addr  = AW'(pos_q >> 3);
  assign bit_mask   = SW'(1) << pos_q[2:0];
  assign bit_hit    = |(mem_rdata & bit_mask);
  assign probe_last = (KW'(probe_cnt_q + KW'(1)) == n_q);
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q <= key_i;
      op_q  <= bfat_pkg::op_e'(op_i);
      m_q   <= m_cfg;
      n_q   <= n_cfg;
      h_q   <= bfat_pkg::FNV_BASIS;
    end
    case (state_q)
      bfat_pkg::ST_HASH: begin
        h_q <= fnv_next;
      end
      bfat_pkg::ST_MUL: begin
        prod_q <= mul_p;
        case (mul_cnt_q)
          2'd1:    h2_q <= prod_q + bfat_pkg::GOLD_ADD;
          2'd2:    h2_q <= h2_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
          2'd3: begin
            h2_q  <= h2_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
            pos_q <= '0;
            h2m_q <= '0;
            t_q   <= RW'(1);
          end
          default: ;
        endcase
      end
      bfat_pkg::ST_DIV: begin
        pos_q <= r1_n;
        h2m_q <= r2_n;
        t_q   <= rt_n;
      end
      bfat_pkg::ST_PREP: begin
        d2_q      <= RW'(d2_calc);
        all_set_q <= 1'b1;
      end
      bfat_pkg::ST_MODIFY: begin
        if (op_q == bfat_pkg::OP_TEST && !bit_hit) begin
          all_set_q <= 1'b0;
        end else begin
          h_q   <= x_sum[KEY_W-1:0];
          pos_q <= r_nx;
        end
      end
      bfat_pkg::ST_DONE: begin
        if (out_load) begin
          present_q <= all_set_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      bfat_pkg::ST_CLEAR: begin
        if (clr_cnt_q == AW'(DEPTH - 1)) state_d = bfat_pkg::ST_IDLE;
      end
      bfat_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bfat_pkg::ST_HASH;
      end
      bfat_pkg::ST_HASH: begin
        if (byte_cnt_q == bfat_pkg::BYTE_CNT_W'(bfat_pkg::KEY_BYTES - 1)) begin
          state_d = bfat_pkg::ST_MUL;
        end
      end
      bfat_pkg::ST_MUL: begin
        if (mul_cnt_q == bfat_pkg::MUL_CW'(bfat_pkg::MUL_STEPS - 1)) begin
          state_d = bfat_pkg::ST_DIV;
        end
      end
      bfat_pkg::ST_DIV: begin
        if (div_cnt_q == bfat_pkg::DIV_CW'(bfat_pkg::DIV_STEPS - 1)) begin
          state_d = bfat_pkg::ST_PREP;
        end
      end
      bfat_pkg::ST_PREP: begin
        state_d = (n_q == '0) ? bfat_pkg::ST_DONE : bfat_pkg::ST_READ;
      end
      bfat_pkg::ST_READ: begin
        state_d = bfat_pkg::ST_MODIFY;
      end
      bfat_pkg::ST_MODIFY: begin
        if ((op_q == bfat_pkg::OP_TEST && !bit_hit) || probe_last) begin
          state_d = bfat_pkg::ST_DONE;
        end else begin
          state_d = bfat_pkg::ST_READ;
        end
      end
      bfat_pkg::ST_DONE: begin
        if (op_q == bfat_pkg::OP_ADD || out_free) state_d = bfat_pkg::ST_IDLE;
      end
      default: state_d = bfat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = byte_addr;
    mem_wdata  = mem_rdata | bit_mask;
    out_load   = 1'b0;
    case (state_q)
      bfat_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      bfat_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      bfat_pkg::ST_READ: begin
        mem_re = 1'b1;
      end
      bfat_pkg::ST_MODIFY: begin
        mem_we = (op_q == bfat_pkg::OP_ADD);
      end
      bfat_pkg::ST_DONE: begin
        out_load = (op_q == bfat_pkg::OP_TEST) && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bfat_pkg::ST_CLEAR;
      clr_cnt_q    <= '0;
      byte_cnt_q   <= '0;
      mul_cnt_q    <= '0;
      div_cnt_q    <= '0;
      probe_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
      bit_count_q  <= bfat_pkg::BIT_COUNT_RST;
      hash_count_q <= bfat_pkg::HASH_COUNT_RST;
    end else begin
      state_q <= state_d;
      if (state_q == bfat_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (state_q == bfat_pkg::ST_HASH) begin
        byte_cnt_q <= byte_cnt_q + bfat_pkg::BYTE_CNT_W'(1);
      end
      if (state_q == bfat_pkg::ST_MUL) begin
        mul_cnt_q <= mul_cnt_q + bfat_pkg::MUL_CW'(1);
      end
      if (state_q == bfat_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + bfat_pkg::DIV_CW'(1);
      end
      if (state_q == bfat_pkg::ST_PREP) begin
        probe_cnt_q <= '0;
      end else if (state_q == bfat_pkg::ST_MODIFY) begin
        probe_cnt_q <= probe_cnt_q + KW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        case (bfat_pkg::reg_idx_e'(paddr[bfat_pkg::PADDR_W-1]))
          bfat_pkg::REG_BIT_COUNT:  bit_count_q  <= pwdata[bfat_pkg::BIT_COUNT_W-1:0];
          bfat_pkg::REG_HASH_COUNT: hash_count_q <= pwdata[bfat_pkg::HASH_COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign present_o   = present_q;

  // ---------------------------------------------------------------------------
  // Filter bit store
  // ---------------------------------------------------------------------------
  bfat_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (byte_addr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pos_below_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfat_pkg::ST_READ) |-> ({1'b0, pos_q} < m_ext))
    else $error("probe position is not below the modulus");

  a_xfer_starts_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == bfat_pkg::ST_HASH))
    else $error("input transfer did not start hashing");

  a_store_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == bfat_pkg::ST_CLEAR ||
                (state_q == bfat_pkg::ST_MODIFY && op_q == bfat_pkg::OP_ADD)))
    else $error("bit store written outside clearing or an add");

  a_probe_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfat_pkg::ST_MODIFY) |-> (probe_cnt_q < n_q))
    else $error("probe count ran past the configured probe number");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfat_pkg::ST_DONE && op_q == bfat_pkg::OP_TEST && !out_free)
      |=> (state_q == bfat_pkg::ST_DONE))
    else $error("test finished while the result register was still full");

endmodule

`default_nettype wire

/* hw/rtl/bfat_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module bfat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* dv/tb_bloom_filter_add_test_core.sv */
// Self-checking testbench for the Bloom filter add/test core with a built-in filter predictor.
module tb_bloom_filter_add_test_core;

  localparam int unsigned     FILTER_BITS   = 65536;
  localparam int unsigned     PROBE_LIMIT   = 16;
  localparam logic [63:0]     FNV_MULT      = 64'h00000100000001b3;
  localparam int unsigned     SETTLE_CYCLES = 80;
  localparam int unsigned     TAIL_CYCLES   = 100;
  localparam int unsigned     STALL_LIMIT   = 50000;
  localparam int unsigned     KNOWN_MAX     = 512;

  typedef struct packed {
    bfat_pkg::op_e op;
    logic [63:0]   key;
  } key_item_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  bfat_pkg::op_e                 op          = bfat_pkg::OP_ADD;
  logic [bfat_pkg::KEY_W-1:0]    key         = '0;
  logic                          out_valid;
  logic                          out_ready   = 1'b1;
  logic                          present;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [bfat_pkg::PADDR_W-1:0]  paddr       = '0;
  logic [bfat_pkg::PDATA_W-1:0]  pwdata      = '0;
  logic [bfat_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  // Predictor state: the filter store and the two configuration registers.
  bit                  filter_mem [0:FILTER_BITS-1];
  logic [16:0]         bits_cfg   = 17'd65536;
  logic [4:0]          probes_cfg = 5'd7;

  key_item_t           pending_keys_q [$];
  logic                present_q [$];
  logic [63:0]         known_keys_q [$];
  int unsigned         n_queued   = 0;
  int unsigned         n_taken    = 0;
  int unsigned         n_errors   = 0;
  int unsigned         stall_cnt  = 0;
  bit                  calm       = 1'b0;

  bloom_filter_add_test_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op),
    .key_i       (key),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .present_o   (present),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  // Hashes the key, walks its probe sequence, and sets or checks the probed bits.
  function automatic logic probe_filter(bfat_pkg::op_e item_op, logic [63:0] item_key);
    logic [63:0] h1;
    logic [63:0] h2;
    logic [63:0] modulus;
    logic [63:0] pos;
    int unsigned n_probes;
    logic        all_set;
    h1 = bfat_pkg::FNV_BASIS;
    for (int i = 0; i < 8; i++) begin
      h1 = h1 ^ {56'd0, item_key[8*i +: 8]};
      h1 = h1 * FNV_MULT;
    end
    h2 = h1 * bfat_pkg::GOLD_MUL + bfat_pkg::GOLD_ADD;
    if (bits_cfg < 17'd64) begin
      modulus = 64'd64;
    end else if (bits_cfg > 17'd65536) begin
      modulus = 64'd65536;
    end else begin
      modulus = 64'(bits_cfg);
    end
    n_probes = (probes_cfg > 5'(PROBE_LIMIT)) ? PROBE_LIMIT : probes_cfg;
    all_set = 1'b1;
    for (int k = 0; k < n_probes; k++) begin
      pos = (h1 + 64'(k) * h2) % modulus;
      if (item_op == bfat_pkg::OP_ADD) begin
        filter_mem[pos[15:0]] = 1'b1;
      end else if (!filter_mem[pos[15:0]]) begin
        all_set = 1'b0;
        break;
      end
    end
    return all_set;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Driver: presents queued items, holding each until its transfer.
  always @(posedge clk_i) begin
    if (!in_valid || in_ready) begin
      if (pending_keys_q.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
        in_valid <= 1'b1;
        op       <= pending_keys_q[0].op;
        key      <= pending_keys_q[0].key;
        void'(pending_keys_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 6);
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk_i) begin : monitor
    logic want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        want = probe_filter(op, key);
        if (op == bfat_pkg::OP_TEST) begin
          present_q.push_back(want);
        end
        n_taken++;
      end
      if (out_valid && out_ready) begin
        if (present_q.size() == 0) begin
          report_mismatch($sformatf("result present=%0b with no test outstanding", present));
        end else begin
          want = present_q.pop_front();
          if (present !== want) begin
            report_mismatch($sformatf("present=%0b, predicted %0b", present, want));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb_bloom_filter_add_test_core failed");
        $finish;
      end
    end
  end

  task automatic apb_write(bfat_pkg::reg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bfat_pkg::REG_BIT_COUNT:  bits_cfg   = data[16:0];
      bfat_pkg::REG_HASH_COUNT: probes_cfg = data[4:0];
      default: ;
    endcase
  endtask

  // Waits until every item is taken and every test answered, then lets a trailing add finish.
  task automatic wait_drained();
    while (n_taken != n_queued || present_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [31:0] bit_count, logic [31:0] hash_count, bit no_idle);
    wait_drained();
    apb_write(bfat_pkg::REG_BIT_COUNT, bit_count | ($urandom() & ~32'h0001ffff));
    apb_write(bfat_pkg::REG_HASH_COUNT, hash_count | ($urandom() & ~32'h0000001f));
    calm = no_idle;
  endtask

  task automatic push_item(bfat_pkg::op_e item_op, logic [63:0] item_key);
    key_item_t item;
    item.op  = item_op;
    item.key = item_key;
    pending_keys_q.push_back(item);
    n_queued++;
    if (item_op == bfat_pkg::OP_ADD) begin
      if (known_keys_q.size() >= KNOWN_MAX) begin
        void'(known_keys_q.pop_front());
      end
      known_keys_q.push_back(item_key);
    end
  endtask

  function automatic logic [63:0] random_key();
    logic [63:0] k;
    case ($urandom_range(15))
      0:       k = '0;
      1:       k = '1;
      2:       k = 64'd1 << $urandom_range(63);
      default: k = {$urandom(), $urandom()};
    endcase
    return k;
  endfunction

  // Adds and tests of keys already added, with tests of fresh keys mixed in.
  task automatic push_random(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        push_item(bfat_pkg::OP_ADD, random_key());
      end else if (pick < 80 && known_keys_q.size() != 0) begin
        push_item(bfat_pkg::OP_TEST,
                  known_keys_q[$urandom_range(known_keys_q.size() - 1)]);
      end else begin
        push_item(bfat_pkg::OP_TEST, random_key());
      end
    end
  endtask

  initial begin : sequencer
    logic [63:0] lone_key;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: extremes of the key and both operations.
    push_item(bfat_pkg::OP_TEST, 64'h0);
    push_item(bfat_pkg::OP_ADD,  64'h0);
    push_item(bfat_pkg::OP_TEST, 64'h0);
    push_item(bfat_pkg::OP_TEST, '1);
    push_item(bfat_pkg::OP_ADD,  '1);
    push_item(bfat_pkg::OP_TEST, '1);
    push_item(bfat_pkg::OP_ADD,  64'h1);
    push_item(bfat_pkg::OP_TEST, 64'h1);
    push_item(bfat_pkg::OP_ADD,  64'h8000_0000_0000_0000);
    push_item(bfat_pkg::OP_TEST, 64'h8000_0000_0000_0000);
    push_item(bfat_pkg::OP_TEST, 64'h2);
    push_item(bfat_pkg::OP_ADD,  64'h0123_4567_89ab_cdef);
    push_item(bfat_pkg::OP_TEST, 64'h0123_4567_89ab_cdef);
    push_item(bfat_pkg::OP_TEST, 64'hfedc_ba98_7654_3210);

    set_cfg(32'd65536, 32'd16, 1'b0);
    push_random(300);
    set_cfg(32'd1000, 32'd3, 1'b0);
    push_random(250);
    // Both registers above their ranges: clamped to the maximum.
    set_cfg(32'd131071, 32'd31, 1'b0);
    push_random(200);

    // No probes: an add leaves the store alone and every test hits.
    set_cfg(32'd4093, 32'd0, 1'b0);
    lone_key = {$urandom(), $urandom()};
    push_item(bfat_pkg::OP_TEST, {$urandom(), $urandom()});
    push_item(bfat_pkg::OP_ADD, lone_key);
    push_item(bfat_pkg::OP_TEST, lone_key);
    push_random(30);

    set_cfg(32'd65537, 32'd1, 1'b1);
    push_item(bfat_pkg::OP_TEST, lone_key);
    push_random(250);
    set_cfg(32'd5000, 32'd9, 1'b0);
    push_random(250);
    // Bit counts below the minimum act as the minimum.
    set_cfg(32'd0, 32'd2, 1'b0);
    push_random(100);
    set_cfg(32'd63, 32'd5, 1'b0);
    push_random(50);
    set_cfg(32'd64, 32'd16, 1'b0);
    push_random(50);
    set_cfg(32'd12345, 32'd7, 1'b0);
    push_random(200);
    set_cfg(32'd100000, 32'd4, 1'b0);
    push_random(150);

    while (n_taken != n_queued || present_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (present_q.size() != 0) begin
      report_mismatch($sformatf("%0d tests never answered", present_q.size()));
    end
    if (n_errors == 0) begin
      $display("tb_bloom_filter_add_test_core passed");
    end else begin
      $display("tb_bloom_filter_add_test_core failed");
    end
    $finish;
  end

endmodule

/* bloom_filter_add_test_core.f */
hw/rtl/bfat_pkg.sv
hw/rtl/bfat_ram.sv
hw/rtl/bloom_filter_add_test_core.sv
dv/tb_bloom_filter_add_test_core.sv
